// ----- src/half_single_float_converter_core_macros.svh -----
// Assertion macros for the half/single converter checker.
// Included by the checker file only.
`ifndef HALF_SINGLE_FLOAT_CONVERTER_CORE_MACROS_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HSFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define HSFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/hsfc_pkg.sv -----
// Shared types and constants for the half/single converter.
// No dependencies.
package hsfc_pkg;

  typedef enum logic {
    FUNC_S2H = 1'b0,
    FUNC_H2S = 1'b1
  } func_e;

  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [30:0] SGL_INF_MAG = 31'h7F80_0000;
  localparam logic [30:0] HALF_INF_AS_SGL = 31'(31) << 23;

endpackage

// ----- src/hsfc_s2h.sv -----
// Single to half conversion, combinational.
// Depends on hsfc_pkg.
module hsfc_s2h import hsfc_pkg::*; (
  input  logic [31:0] op_i,
  output logic [15:0] res_o
);

  logic [30:0] mag;
  logic [30:0] mant;
  logic [7:0]  e;
  logic [23:0] sig;
  logic [6:0]  s;
  logic [23:0] q;
  logic [23:0] rem;
  logic [23:0] half;
  logic [30:0] scaled;
  logic [30:0] sum;
  logic [14:0] r;

  always_comb begin
    mag  = op_i[30:0];
    mant = {mag[30:12], 12'h000};
    e    = mant[30:23];
    sig  = {1'b1, mant[22:0]};
    s    = 7'(8'd113 - e);
    q    = '0;
    rem  = '0;
    half = '0;
    if (e >= 8'd113) begin
      scaled = mant - (31'(112) << 23);
    end else if (e == 8'd0 || s >= 7'd25) begin
      scaled = '0;
    end else begin
      q    = sig >> s;
      rem  = sig & ((24'd1 << s) - 24'd1);
      half = 24'd1 << (s - 7'd1);
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      scaled = 31'(q);
    end
    sum = scaled + 31'h1000;
    if (sum > HALF_INF_AS_SGL) sum = HALF_INF_AS_SGL;
    r = sum[27:13];
    if (mag > SGL_INF_MAG)       res_o = {op_i[31], HALF_QNAN[14:0]};
    else if (mag == SGL_INF_MAG) res_o = {op_i[31], HALF_INF[14:0]};
    else                         res_o = {op_i[31], r};
  end

endmodule

// ----- src/hsfc_h2s.sv -----
// Half to single conversion, combinational.
// Depends on hsfc_pkg.
module hsfc_h2s import hsfc_pkg::*; (
  input  logic [15:0] op_i,
  output logic [31:0] res_o
);

  logic [4:0]  ex;
  logic [9:0]  man;
  logic [3:0]  p;
  logic [22:0] frac;
  logic [30:0] mag;

  always_comb begin
    ex  = op_i[14:10];
    man = op_i[9:0];
    p   = '0;
    // leading one position of a subnormal mantissa
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    frac = 23'({man, 13'd0} << (4'd10 - p));
    if (ex == 5'd0) begin
      if (man == 10'd0) mag = '0;
      else              mag = {8'(p) + 8'd103, frac};
    end else if (ex == 5'h1F) begin
      mag = {8'hFF, man, 13'd0};
    end else begin
      mag = {8'(ex) + 8'd112, man, 13'd0};
    end
    res_o = {op_i[15], mag};
  end

endmodule

// ----- src/half_single_float_converter_core.sv -----
// Half/single float converter: start is captured in the input register, then the result
// register drives valid_o; throughput one conversion per cycle.
// busy is always low; the receiver cannot stall, each result shows for one cycle.
// Reset (asynchronous, active low) clears the valid flags; data registers are not reset.
// Depends on hsfc_pkg, hsfc_s2h, hsfc_h2s.
module half_single_float_converter_core import hsfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] operand_i,
  output logic        valid_o,
  output logic [31:0] result_o
);

  logic        in_vld_q;
  logic        func_q;
  logic [31:0] op_q;
  logic [15:0] s2h;
  logic [31:0] h2s;
  logic [31:0] res_d;
  logic [31:0] res_q;
  logic        out_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      func_q <= func_i;
      op_q   <= operand_i;
    end
    if (in_vld_q) res_q <= res_d;
  end

  hsfc_s2h u_s2h (.op_i(op_q), .res_o(s2h));
  hsfc_h2s u_h2s (.op_i(op_q[15:0]), .res_o(h2s));

  assign res_d    = (func_e'(func_q) == FUNC_H2S) ? h2s : {16'd0, s2h};
  assign valid_o  = out_vld_q;
  assign result_o = res_q;

endmodule

// ----- src/hsfc_checker.sv -----
// Port-level checker for the converter, bound to the top level.
// Depends on half_single_float_converter_core_macros.svh.
`include "half_single_float_converter_core_macros.svh"
module hsfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        func_i,
  input logic        valid_o,
  input logic [31:0] result_o
);

  `HSFC_ASSERT_IMP(a_never_busy, clk_i, rst_ni, 1'b1, !busy)
  `HSFC_ASSERT_NXT(a_latency, clk_i, rst_ni, start && !busy, ##1 valid_o)
  `HSFC_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !start, ##1 !valid_o)
  `HSFC_ASSERT_NXT(a_half_upper_zero, clk_i, rst_ni, start && !func_i,
    ##1 result_o[31:16] == 16'd0)

endmodule

bind half_single_float_converter_core hsfc_checker u_hsfc_checker (.*);

// ----- tb/tb.sv -----
// Testbench for half_single_float_converter_core: directed and random conversions
// checked against an in-bench bit-exact predictor. Depends on hsfc_pkg and the core.
module tb import hsfc_pkg::*; ();

  class conv_scoreboard;
    logic [31:0] expected_q[$];
    int          n_fail;

    function new();
      n_fail = 0;
    endfunction

    // scale a non-negative finite single by 2^-112, round to nearest even
    static function logic [31:0] scale_down(logic [31:0] bits);
      logic [31:0] e, sig, q, rem, hlf;
      int          s;
      e = bits >> 23;
      if (e >= 113) return bits - (32'd112 << 23);
      if (e == 0) return 32'd0;
      sig = (bits & 32'h007F_FFFF) | 32'h0080_0000;
      s = 113 - e;
      if (s >= 25) return 32'd0;
      q = sig >> s;
      rem = sig & ((32'd1 << s) - 1);
      hlf = 32'd1 << (s - 1);
      if (rem > hlf || (rem == hlf && q[0])) q = q + 1;
      return q;
    endfunction

    static function logic [31:0] to_half(logic [31:0] x);
      logic [31:0] mag;
      logic [15:0] r;
      mag = {1'b0, x[30:0]};
      if (mag >= {1'b0, SGL_INF_MAG}) begin
        r = (mag > {1'b0, SGL_INF_MAG}) ? HALF_QNAN : HALF_INF;
      end else begin
        mag = scale_down(mag & ~32'hFFF) + 32'h1000;
        if (mag > {1'b0, HALF_INF_AS_SGL}) mag = {1'b0, HALF_INF_AS_SGL};
        r = mag[28:13];
      end
      r[15] = r[15] | x[31];
      return {16'd0, r};
    endfunction

    static function logic [31:0] to_single(logic [31:0] x);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [31:0] r;
      int          p;
      ex = x[14:10];
      man = x[9:0];
      if (ex == 0) begin
        if (man == 0) begin
          r = 0;
        end else begin
          p = 9;
          while (!man[p]) p--;
          r = ((p + 103) << 23) | ((32'(man) << (23 - p)) & 32'h007F_FFFF);
        end
      end else begin
        r = 32'(man) << 13;
        if (ex == 5'h1F) r = r | 32'h7F80_0000;
        else r = r | ((32'd112 + ex) << 23);
      end
      r[31] = x[15];
      return r;
    endfunction

    function void note_input(func_e f, logic [31:0] op);
      expected_q.push_back(f == FUNC_H2S ? to_single(op) : to_half(op));
    endfunction

    function void check_result(logic [31:0] res);
      logic [31:0] exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", res);
        n_fail++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (res !== exp_r) begin
        $error("result: expected %h actual %h", exp_r, res);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = 1'b0;
  logic [31:0] operand_i = '0;
  logic        valid_o;
  logic [31:0] result_o;
  int          idle_pct = 23;
  int          quiet_cycles = 0;
  conv_scoreboard conv_sb = new();

  always #2 clk_i = ~clk_i;

  half_single_float_converter_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .operand_i, .valid_o, .result_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) conv_sb.note_input(func_e'(func_i), operand_i);
    if (rst_ni && valid_o) conv_sb.check_result(result_o);
    quiet_cycles = (start && !busy) || valid_o ? 0 : quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // one transaction; start stays high between back-to-back items
  task automatic convert(func_e f, logic [31:0] op);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    operand_i <= op;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'($urandom_range(100, 114));   // near the half subnormal edge
      1: v[30:23] = 8'($urandom_range(140, 143));   // near overflow
      2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3: v[11:0] = $urandom_range(0, 1) ? 12'h000 : 12'hFFF;
      default: v[30:23] = 8'($urandom_range(113, 142));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v[14:10] = 5'd0;
      1: v[14:10] = 5'h1F;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes and special cases
    convert(FUNC_S2H, 32'h0000_0000);
    convert(FUNC_S2H, 32'h8000_0000);
    convert(FUNC_S2H, 32'h7F80_0000);
    convert(FUNC_S2H, 32'hFF80_0000);
    convert(FUNC_S2H, 32'h7F80_0001);   // signalling NaN
    convert(FUNC_S2H, 32'hFFFF_FFFF);
    convert(FUNC_S2H, 32'h0000_0001);   // single subnormal
    convert(FUNC_S2H, 32'h477F_F000);   // ties up to infinity
    convert(FUNC_S2H, 32'h477F_E000);
    convert(FUNC_S2H, 32'h7F7F_FFFF);
    convert(FUNC_S2H, 32'h3F80_0000);
    convert(FUNC_S2H, 32'h3880_0000);
    convert(FUNC_S2H, 32'h3380_0000);
    convert(FUNC_S2H, 32'h3300_0000);
    convert(FUNC_S2H, 32'hB87F_F000);
    convert(FUNC_H2S, 32'h0000_0000);
    convert(FUNC_H2S, 32'hFFFF_8000);   // upper bits ignored
    convert(FUNC_H2S, 32'h0000_0001);
    convert(FUNC_H2S, 32'h0000_03FF);
    convert(FUNC_H2S, 32'h0000_7C00);
    convert(FUNC_H2S, 32'h0000_FC01);   // half signalling NaN
    convert(FUNC_H2S, 32'hA5A5_7BFF);
    convert(FUNC_H2S, 32'h0000_FFFF);
    for (int i = 0; i < 700; i++) begin
      if (i == 230) idle_pct = 80;
      if (i == 460) idle_pct = 0;
      if ($urandom_range(1)) convert(FUNC_H2S, rand_half());
      else convert(FUNC_S2H, rand_single());
    end
    start <= 1'b0;
    while (conv_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (conv_sb.n_fail == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
